// ===== src/nace_pkg.sv =====
// Shared package for the NLFSR authenticated cipher engine.
// Holds item and frame codes, the group counts and the control struct
// that passes from the sequencer to the NLFSR core. No dependencies.
package nace_pkg;

    // Input item kinds, as carried in the low bits of the request's tuser.
    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_AD     = 2'd1;
    localparam logic [1:0] KIND_MSG    = 2'd2;
    localparam logic [1:0] KIND_FINISH = 2'd3;

    // Result kinds.
    localparam logic OUT_TEXT = 1'b0;
    localparam logic OUT_TAG  = 1'b1;

    // Frame bits XORed into state word 1 ahead of each update after key setup.
    localparam logic [7:0] FRAME_NONCE = 8'h10;
    localparam logic [7:0] FRAME_AD    = 8'h30;
    localparam logic [7:0] FRAME_TEXT  = 8'h50;
    localparam logic [7:0] FRAME_FINAL = 8'h70;

    // The core advances 32 NLFSR steps per cycle in which step is set.
    localparam int STEPS_PER_GROUP = 32;
    localparam int STEPS_SHORT     = 128 * 5;
    localparam int STEPS_LONG      = 128 * 10;
    localparam int CNT_W           = 6;
    localparam logic [CNT_W-1:0] LAST_SHORT = CNT_W'(STEPS_SHORT / STEPS_PER_GROUP - 1);
    localparam logic [CNT_W-1:0] LAST_LONG  = CNT_W'(STEPS_LONG / STEPS_PER_GROUP - 1);

    // Work for the NLFSR core in the current cycle. Clear wins over step, and
    // step wins over the two XOR terms.
    typedef struct packed {
        logic        clear;
        logic        step;
        logic [1:0]  kidx;
        logic [7:0]  x1;
        logic [31:0] x3;
    } t_core_ctl;

    // Byte mask for a clamped count of 1 to 4 bytes (0 gives no bytes).
    function automatic logic [31:0] byte_mask(input logic [2:0] nb);
        logic [31:0] m;
        case (nb)
            3'd0:    m = 32'h0000_0000;
            3'd1:    m = 32'h0000_00ff;
            3'd2:    m = 32'h0000_ffff;
            3'd3:    m = 32'h00ff_ffff;
            default: m = 32'hffff_ffff;
        endcase
        return m;
    endfunction

endpackage

// ===== src/nace_nlfsr.sv =====
// NLFSR core: the 128-bit cipher state held as a line of four 32-bit words.
// Each step cycle shifts in one feedback word (32 NLFSR steps).
// Depends on nace_pkg for the control struct.
module nace_nlfsr
    import nace_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_core_ctl   i_ctl,
    input  logic [63:0] i_key_low,
    input  logic [63:0] i_key_high,
    output logic [31:0] o_s2
);

    logic [31:0] r_s [4];
    logic [31:0] n_s [4];
    logic [31:0] w_key;
    logic [31:0] w_a;
    logic [31:0] w_b;
    logic [31:0] w_c;
    logic [31:0] w_d;
    logic [31:0] w_fb;

    // Key word for this group of 32 steps.
    always_comb begin
        case (i_ctl.kidx)
            2'd0:    w_key = i_key_low[31:0];
            2'd1:    w_key = i_key_low[63:32];
            2'd2:    w_key = i_key_high[31:0];
            default: w_key = i_key_high[63:32];
        endcase
    end

    // Feedback word: 32 NLFSR steps computed side by side.
    assign w_a  = {r_s[2][14:0], r_s[1][31:15]};
    assign w_b  = {r_s[3][5:0],  r_s[2][31:6]};
    assign w_c  = {r_s[3][20:0], r_s[2][31:21]};
    assign w_d  = {r_s[3][26:0], r_s[2][31:27]};
    assign w_fb = r_s[0] ^ w_a ^ ~(w_b & w_c) ^ w_d ^ w_key;

    // Next state: clear, shift by one word, or absorb frame bits and data.
    always_comb begin
        n_s = r_s;
        if (i_ctl.clear) begin
            n_s[0] = '0;
            n_s[1] = '0;
            n_s[2] = '0;
            n_s[3] = '0;
        end else if (i_ctl.step) begin
            n_s[0] = r_s[1];
            n_s[1] = r_s[2];
            n_s[2] = r_s[3];
            n_s[3] = w_fb;
        end else begin
            n_s[1] = r_s[1] ^ {24'd0, i_ctl.x1};
            n_s[3] = r_s[3] ^ i_ctl.x3;
        end
    end

    // State register, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s[0] <= '0;
            r_s[1] <= '0;
            r_s[2] <= '0;
            r_s[3] <= '0;
        end else begin
            r_s <= n_s;
        end
    end

    assign o_s2 = r_s[2];

endmodule

// ===== src/nlfsr_aead_cipher_engine_unit.sv =====
// Top level of the NLFSR authenticated cipher engine: stream ports, key
// registers, the update sequencer and the result register.
// Depends on nace_pkg and nace_nlfsr.
//
//  Channel   Direction  Handshake              Contents
//  s_        in         i_s_tvalid/o_s_tready  one request: start, AD word, text word, finish
//  m_        out        o_m_tvalid/i_m_tready  text word or tag result
//  cfg_      in         i_cfg_we               key_low (index 0), key_high (index 1)
//
// One request is processed at a time; 32 NLFSR steps run per update cycle.
// An AD or text word with zero bytes runs no update.
// The long update of the NLFSR core sets the text-word rate.
// A stalled result holds the sequencer only when the next result is due.
// Reset is synchronous, active low, and clears the state and the keys.
module nlfsr_aead_cipher_engine_unit
    import nace_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // [31:0] data_word, [34:32] valid_bytes, [98:35] nonce_low,
    // [130:99] nonce_high, [194:131] tag_in, [199:195] zero
    input  logic [199:0] i_s_tdata,
    // [1:0] kind, [2] decrypt
    input  logic [2:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // [31:0] out_word, [34:32] out_bytes, [98:35] tag_out, [99] tag_ok,
    // [103:100] zero
    output logic [103:0] o_m_tdata,
    // [0] out_kind
    output logic [0:0]   o_m_tuser,
    input  logic         i_cfg_we,
    input  logic [0:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_wdata
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CLEAR  = 3'd1;
    localparam logic [2:0] S_FRAME  = 3'd2;
    localparam logic [2:0] S_RUN    = 3'd3;
    localparam logic [2:0] S_ABSORB = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_long, n_long;
    logic [1:0]       r_round, n_round;
    logic [1:0]       r_kind, n_kind;
    logic             r_dec, n_dec;
    logic [31:0]      r_word, n_word;
    logic [2:0]       r_nb, n_nb;
    logic [95:0]      r_nonce, n_nonce;
    logic [63:0]      r_tag_in, n_tag_in;
    logic [31:0]      r_t0, n_t0;
    logic [63:0]      r_key_low, r_key_high;

    logic             r_ov, n_ov;
    logic             r_okind, n_okind;
    logic [31:0]      r_oword, n_oword;
    logic [2:0]       r_obytes, n_obytes;
    logic [63:0]      r_otag, n_otag;
    logic             r_took, n_took;

    t_core_ctl        w_ctl;
    logic [31:0]      w_s2;
    logic             w_s_acc;
    logic             w_out_load;
    logic             w_out_free;
    logic [2:0]       w_nb_in;
    logic [31:0]      w_mask;
    logic [31:0]      w_res;
    logic [31:0]      w_plain;
    logic [7:0]       w_nb_x1;
    logic [7:0]       w_frame;
    logic [31:0]      w_nonce_word;
    logic [CNT_W-1:0] w_last;
    logic [63:0]      w_tag;

    nace_nlfsr u_nlfsr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_key_low  (r_key_low),
        .i_key_high (r_key_high),
        .o_s2       (w_s2)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign w_s_acc    = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_ov || i_m_tready;

    // Byte count clamped to four; zero stays zero.
    assign w_nb_in = (i_s_tdata[34:32] > 3'd4) ? 3'd4 : i_s_tdata[34:32];

    // Text path and partial-word length term.
    assign w_mask  = byte_mask(r_nb);
    assign w_res   = (w_s2 ^ r_word) & w_mask;
    assign w_plain = r_dec ? w_res : (r_word & w_mask);
    assign w_nb_x1 = (r_nb < 3'd4) ? {5'd0, r_nb} : 8'd0;
    assign w_tag   = {w_s2, r_t0};
    assign w_last  = r_long ? LAST_LONG : LAST_SHORT;

    // Frame bits for the update that belongs to this request.
    always_comb begin
        case (r_kind)
            KIND_START: w_frame = FRAME_NONCE;
            KIND_AD:    w_frame = FRAME_AD;
            KIND_MSG:   w_frame = FRAME_TEXT;
            default:    w_frame = FRAME_FINAL;
        endcase
    end

    // Nonce word absorbed after each short update of a start; none after key setup.
    always_comb begin
        case (r_round)
            2'd1:    w_nonce_word = r_nonce[31:0];
            2'd2:    w_nonce_word = r_nonce[63:32];
            2'd3:    w_nonce_word = r_nonce[95:64];
            default: w_nonce_word = 32'd0;
        endcase
    end

    // Sequencer: frame, update groups, absorb, and load the result.
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_long     = r_long;
        n_round    = r_round;
        n_kind     = r_kind;
        n_dec      = r_dec;
        n_word     = r_word;
        n_nb       = r_nb;
        n_nonce    = r_nonce;
        n_tag_in   = r_tag_in;
        n_t0       = r_t0;
        n_okind    = r_okind;
        n_oword    = r_oword;
        n_obytes   = r_obytes;
        n_otag     = r_otag;
        n_took     = r_took;
        w_ctl      = '0;
        w_out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_s_acc) begin
                    n_kind   = i_s_tuser[1:0];
                    n_dec    = i_s_tuser[2];
                    n_word   = i_s_tdata[31:0];
                    n_nb     = w_nb_in;
                    n_nonce  = i_s_tdata[130:35];
                    n_tag_in = i_s_tdata[194:131];
                    n_round  = 2'd0;
                    n_cnt    = '0;
                    if (i_s_tuser[1:0] == KIND_START) begin
                        n_state = S_CLEAR;
                    end else if (w_nb_in != 3'd0 || i_s_tuser[1:0] == KIND_FINISH) begin
                        n_state = S_FRAME;
                        n_long  = (i_s_tuser[1:0] != KIND_AD);
                    end
                end
            end
            S_CLEAR: begin
                w_ctl.clear = 1'b1;
                n_long      = 1'b1;
                n_cnt       = '0;
                n_state     = S_RUN;
            end
            S_FRAME: begin
                w_ctl.x1 = w_frame;
                n_cnt    = '0;
                n_state  = S_RUN;
            end
            S_RUN: begin
                w_ctl.step = 1'b1;
                w_ctl.kidx = r_cnt[1:0];
                if (r_cnt == w_last) begin
                    n_state = S_ABSORB;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_ABSORB: begin
                case (r_kind)
                    KIND_START: begin
                        w_ctl.x3 = w_nonce_word;
                        if (r_round == 2'd3) begin
                            n_state = S_IDLE;
                        end else begin
                            n_round = r_round + 1'b1;
                            n_long  = 1'b0;
                            n_state = S_FRAME;
                        end
                    end
                    KIND_AD: begin
                        w_ctl.x3 = r_word & w_mask;
                        w_ctl.x1 = w_nb_x1;
                        n_state  = S_IDLE;
                    end
                    KIND_MSG: begin
                        if (w_out_free) begin
                            w_ctl.x3   = w_plain;
                            w_ctl.x1   = w_nb_x1;
                            w_out_load = 1'b1;
                            n_okind    = OUT_TEXT;
                            n_oword    = w_res;
                            n_obytes   = r_nb;
                            n_otag     = '0;
                            n_took     = 1'b0;
                            n_state    = S_IDLE;
                        end
                    end
                    default: begin
                        if (r_round == 2'd0) begin
                            n_t0    = w_s2;
                            n_round = 2'd1;
                            n_long  = 1'b0;
                            n_state = S_FRAME;
                        end else if (w_out_free) begin
                            w_out_load = 1'b1;
                            n_okind    = OUT_TAG;
                            n_oword    = '0;
                            n_obytes   = '0;
                            n_otag     = w_tag;
                            n_took     = r_dec && (w_tag == r_tag_in);
                            n_state    = S_IDLE;
                        end
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The result register is held until the downstream side takes it.
    assign n_ov = w_out_load || (r_ov && !i_m_tready);

    // Control registers and keys.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_long     <= 1'b0;
            r_round    <= 2'd0;
            r_ov       <= 1'b0;
            r_key_low  <= '0;
            r_key_high <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_long  <= n_long;
            r_round <= n_round;
            r_ov    <= n_ov;
            if (i_cfg_we && i_cfg_index == 1'b0) begin
                r_key_low <= i_cfg_wdata;
            end
            if (i_cfg_we && i_cfg_index == 1'b1) begin
                r_key_high <= i_cfg_wdata;
            end
        end
    end

    // Request and result payload registers.
    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_dec    <= n_dec;
        r_word   <= n_word;
        r_nb     <= n_nb;
        r_nonce  <= n_nonce;
        r_tag_in <= n_tag_in;
        r_t0     <= n_t0;
        r_okind  <= n_okind;
        r_oword  <= n_oword;
        r_obytes <= n_obytes;
        r_otag   <= n_otag;
        r_took   <= n_took;
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {4'd0, r_took, r_otag, r_obytes, r_oword};
    assign o_m_tuser  = r_okind;

    // A new result never overwrites one that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> (!r_ov || i_m_tready))
        else $error("result register overwritten while pending");

    // The group counter never passes the end of the current update.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_cnt <= w_last))
        else $error("group counter beyond update length");

    // Clearing the state is always followed by the long key update.
    a_clear_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |=> (r_state == S_RUN && r_cnt == '0 && r_long))
        else $error("key setup did not follow a state clear");

    // The last group of an update always leads to absorption.
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_cnt == w_last) |=> (r_state == S_ABSORB))
        else $error("update ended without absorption");

endmodule
